>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every check is sampled on aclk and is held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

`endif

>>> design/lwaa_pkg.sv
package lwaa_pkg;

    // Sizes of the node set and the request queue.
    localparam int MAX_NODES = 16;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int LEN_W     = IDX_W + 1;

    // Field widths.
    localparam int OP_W      = 3;
    localparam int NODE_W    = 4;
    localparam int TIME_W    = 32;
    localparam int WEIGHT_W  = 8;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 12;
    localparam int AHEAD_W   = 12;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_REMOTE_REQUEST = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOTE_ACK     = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOTE_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_LOCAL_REQUEST  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOCAL_RELEASE  = 3'd4;

    // Outgoing message kinds.
    localparam logic [KIND_W-1:0] SEND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] SEND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] SEND_REQUEST = 2'd2;
    localparam logic [KIND_W-1:0] SEND_RELEASE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_WEIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd3;

    // Configuration reset values.
    localparam logic [NODE_W-1:0]   MY_RANK_RESET    = 4'd0;
    localparam logic [COUNT_W-1:0]  NODE_COUNT_RESET = 5'd1;
    localparam logic [WEIGHT_W-1:0] MY_WEIGHT_RESET  = 8'd70;
    localparam logic [CAP_W-1:0]    CAPACITY_RESET   = 12'd150;

    // Configuration registers as one group.
    typedef struct packed {
        logic [NODE_W-1:0]   my_rank;
        logic [COUNT_W-1:0]  node_count;
        logic [WEIGHT_W-1:0] my_weight;
        logic [CAP_W-1:0]    capacity;
    } cfg_t;

    // One queue entry: 44 bits.
    typedef struct packed {
        logic [TIME_W-1:0]   stamp;
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
    } entry_t;

    // Sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_INS_ISSUE = 8'b0000_0010,
        ST_INS_CMP   = 8'b0000_0100,
        ST_DEL_ISSUE = 8'b0000_1000,
        ST_DEL_SCAN  = 8'b0001_0000,
        ST_SUM_ISSUE = 8'b0010_0000,
        ST_SUM_SCAN  = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    // Saturating clock increment.
    function automatic logic [TIME_W-1:0] clock_bump(input logic [TIME_W-1:0] base);
        logic [TIME_W-1:0] result;
        result = (base == '1) ? base : base + 1'b1;
        return result;
    endfunction

    // Queue order: time first, then node id.
    function automatic logic key_less(input entry_t a, input entry_t b);
        logic result;
        result = (a.stamp < b.stamp) || ((a.stamp == b.stamp) && (a.node < b.node));
        return result;
    endfunction

endpackage

>>> design/lamport_weighted_admission_arbiter_core.sv
// Admission arbiter for one node of a Lamport-clock mutual exclusion group.
// Input channel (s_*): one message or local event per transfer: remote
// request, remote ack, remote release, local request or local release.
// Result channel (m_*): exactly one result per input transfer, giving the
// message to send, its clock value, the grant flag, the weight queued ahead
// of the own entry and a flag for an insert dropped on a full queue.
// Configuration channel (cfg_*): writes rank, node count, own weight and
// capacity; it is always ready. The user writes it only while the block is
// idle; the block itself does not enforce this. The request queue lives in
// a 16-entry memory with a registered read port. An insert into a queue
// that is not full, or a delete, does one pass over the queue (one entry
// per cycle, shifting entries in place); then, for every known operation,
// one pass sums the weights ahead of the own entry if the queue is not
// empty. The next input is taken as soon as the sequencer returns to idle,
// even while the previous result still waits in the output register. A
// stalled receiver holds the result register; a further item is then held
// in its final state until the register frees. Reset clears the clock, the
// queue length and the acks and loads the configuration reset values.
`include "assert_macros.svh"

module lamport_weighted_admission_arbiter_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lwaa_pkg::OP_W-1:0]           s_operation,
    input  logic [lwaa_pkg::NODE_W-1:0]         s_source_node,
    input  logic [lwaa_pkg::TIME_W-1:0]         s_stamp,
    input  logic [lwaa_pkg::WEIGHT_W-1:0]       s_request_weight,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lwaa_pkg::KIND_W-1:0]         m_send_kind,
    output logic [lwaa_pkg::TIME_W-1:0]         m_out_time,
    output logic                                m_grant,
    output logic [lwaa_pkg::AHEAD_W-1:0]        m_weight_ahead,
    output logic                                m_queue_full,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lwaa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwaa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lwaa_pkg::*;

    // Control state.
    state_t               state_reg, state_next;
    cfg_t                 cfg_reg, cfg_next;
    logic [TIME_W-1:0]    clock_reg, clock_next;
    logic [MAX_NODES-1:0] ack_reg, ack_next;
    logic [LEN_W-1:0]     q_len_reg, q_len_next;
    logic                 m_valid_reg, m_valid_next;

    // Working registers of the current item.
    logic [OP_W-1:0]      op_reg, op_next;
    entry_t               new_entry_reg, new_entry_next;
    logic [NODE_W-1:0]    del_node_reg, del_node_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [AHEAD_W-1:0]   sum_reg, sum_next;
    logic                 full_reg, full_next;

    // Result register.
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [TIME_W-1:0]    m_time_reg, m_time_next;
    logic                 m_grant_reg, m_grant_next;
    logic [AHEAD_W-1:0]   m_ahead_reg, m_ahead_next;
    logic                 m_full_reg, m_full_next;

    // Queue memory ports.
    entry_t               q_mem [MAX_NODES];
    entry_t               q_rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic                 in_xfer;
    logic                 out_free;
    logic                 last_entry;
    logic                 grant_ok;
    logic [TIME_W-1:0]    stamp_max;

    assign in_xfer    = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_entry = ((LEN_W'(idx_reg) + 1'b1) == q_len_reg);
    assign stamp_max  = (clock_reg > s_stamp) ? clock_reg : s_stamp;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Grant condition on the updated state.
    lwaa_grant_eval u_grant_eval (
        .cfg          (cfg_reg),
        .ack_bits     (ack_reg),
        .weight_ahead (sum_reg),
        .grant_ok     (grant_ok)
    );

    // Queue memory: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            q_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_rd_data_reg <= q_mem[rd_addr];
        end
    end

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MY_RANK:    cfg_next.my_rank    = cfg_data[NODE_W-1:0];
                CFG_NODE_COUNT: cfg_next.node_count = cfg_data[COUNT_W-1:0];
                CFG_MY_WEIGHT:  cfg_next.my_weight  = cfg_data[WEIGHT_W-1:0];
                CFG_CAPACITY:   cfg_next.capacity   = cfg_data[CAP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Sequencer: accept, queue pass, weight pass, result.
    always_comb begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        ack_next       = ack_reg;
        q_len_next     = q_len_reg;
        op_next        = op_reg;
        new_entry_next = new_entry_reg;
        del_node_next  = del_node_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        sum_next       = sum_reg;
        full_next      = full_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_time_next    = m_time_reg;
        m_grant_next   = m_grant_reg;
        m_ahead_next   = m_ahead_reg;
        m_full_next    = m_full_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = new_entry_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    op_next   = s_operation;
                    full_next = 1'b0;
                    case (s_operation)
                        OP_REMOTE_REQUEST: begin
                            clock_next     = clock_bump(stamp_max);
                            new_entry_next = '{stamp: s_stamp, node: s_source_node,
                                               weight: s_request_weight};
                            if (q_len_reg == LEN_W'(MAX_NODES)) begin
                                full_next  = 1'b1;
                                state_next = ST_SUM_ISSUE;
                            end else begin
                                idx_next   = q_len_reg[IDX_W-1:0];
                                state_next = ST_INS_ISSUE;
                            end
                        end
                        OP_REMOTE_ACK: begin
                            ack_next[s_source_node[IDX_W-1:0]] = 1'b1;
                            state_next = ST_SUM_ISSUE;
                        end
                        OP_REMOTE_RELEASE: begin
                            del_node_next = s_source_node;
                            state_next    = ST_DEL_ISSUE;
                        end
                        OP_LOCAL_REQUEST: begin
                            clock_next     = clock_bump(clock_reg);
                            new_entry_next = '{stamp: clock_bump(clock_reg),
                                               node: cfg_reg.my_rank,
                                               weight: cfg_reg.my_weight};
                            if (q_len_reg == LEN_W'(MAX_NODES)) begin
                                full_next  = 1'b1;
                                state_next = ST_SUM_ISSUE;
                            end else begin
                                idx_next   = q_len_reg[IDX_W-1:0];
                                state_next = ST_INS_ISSUE;
                            end
                        end
                        OP_LOCAL_RELEASE: begin
                            ack_next      = '0;
                            del_node_next = cfg_reg.my_rank;
                            state_next    = ST_DEL_ISSUE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // Insert: walk down from the tail, moving larger keys up one slot.
            ST_INS_ISSUE: begin
                if (idx_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = new_entry_reg;
                    q_len_next = q_len_reg + 1'b1;
                    state_next = ST_SUM_ISSUE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_reg - 1'b1;
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (!key_less(q_rd_data_reg, new_entry_reg)) begin
                    wr_data  = q_rd_data_reg;
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg == IDX_W'(1)) begin
                        state_next = ST_INS_ISSUE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_reg - IDX_W'(2);
                    end
                end else begin
                    wr_data    = new_entry_reg;
                    q_len_next = q_len_reg + 1'b1;
                    state_next = ST_SUM_ISSUE;
                end
            end

            // Delete: find the first matching entry, then pull the rest down.
            ST_DEL_ISSUE: begin
                if (q_len_reg == '0) begin
                    state_next = ST_SUM_ISSUE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = ST_DEL_SCAN;
                end
            end

            ST_DEL_SCAN: begin
                if (found_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - 1'b1;
                    wr_data = q_rd_data_reg;
                end
                found_next = found_reg || (q_rd_data_reg.node == del_node_reg);
                if (last_entry) begin
                    if (found_next) begin
                        q_len_next = q_len_reg - 1'b1;
                    end
                    state_next = ST_SUM_ISSUE;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Weight pass: sum entries ahead of the first own entry.
            ST_SUM_ISSUE: begin
                sum_next = '0;
                if (q_len_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = ST_SUM_SCAN;
                end
            end

            ST_SUM_SCAN: begin
                if (q_rd_data_reg.node == cfg_reg.my_rank) begin
                    state_next = ST_DONE;
                end else begin
                    sum_next = sum_reg + AHEAD_W'(q_rd_data_reg.weight);
                    if (last_entry) begin
                        state_next = ST_DONE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            // Load the result register once it is free.
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ahead_next = sum_reg;
                    m_full_next  = full_reg;
                    m_time_next  = clock_reg;
                    m_grant_next = 1'b0;
                    case (op_reg) inside
                        OP_REMOTE_REQUEST: begin
                            m_kind_next = SEND_ACK;
                        end
                        OP_REMOTE_ACK, OP_REMOTE_RELEASE: begin
                            m_kind_next  = SEND_NONE;
                            m_time_next  = '0;
                            m_grant_next = grant_ok;
                        end
                        OP_LOCAL_REQUEST: begin
                            m_kind_next  = SEND_REQUEST;
                            m_grant_next = grant_ok;
                        end
                        OP_LOCAL_RELEASE: begin
                            m_kind_next = SEND_RELEASE;
                        end
                        default: begin
                            m_kind_next  = SEND_NONE;
                            m_time_next  = '0;
                            m_ahead_next = '0;
                            m_full_next  = 1'b0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= '{my_rank: MY_RANK_RESET, node_count: NODE_COUNT_RESET,
                             my_weight: MY_WEIGHT_RESET, capacity: CAPACITY_RESET};
            clock_reg   <= '0;
            ack_reg     <= '0;
            q_len_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            clock_reg   <= clock_next;
            ack_reg     <= ack_next;
            q_len_reg   <= q_len_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        new_entry_reg <= new_entry_next;
        del_node_reg  <= del_node_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        sum_reg       <= sum_next;
        full_reg      <= full_next;
        m_kind_reg    <= m_kind_next;
        m_time_reg    <= m_time_next;
        m_grant_reg   <= m_grant_next;
        m_ahead_reg   <= m_ahead_next;
        m_full_reg    <= m_full_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_send_kind    = m_kind_reg;
    assign m_out_time     = m_time_reg;
    assign m_grant        = m_grant_reg;
    assign m_weight_ahead = m_ahead_reg;
    assign m_queue_full   = m_full_reg;

    // Design checks.
    `ASSERT_CLK(a_len_bound, q_len_reg <= LEN_W'(MAX_NODES), "queue length above capacity")
    `ASSERT_IMPLY(a_ins_idx, state_reg == ST_INS_CMP, idx_reg != '0,
        "insert compare with slot zero")
    `ASSERT_IMPLY(a_result_src, $rose(m_valid_reg), $past(state_reg) == ST_DONE,
        "result loaded outside final state")
    `ASSERT_IMPLY(a_len_step, $past(aresetn),
        (q_len_reg == $past(q_len_reg)) || (q_len_reg == $past(q_len_reg) + 1'b1) ||
        (q_len_reg == $past(q_len_reg) - 1'b1), "queue length jumped")

endmodule

>>> design/lwaa_grant_eval.sv
module lwaa_grant_eval (
    input  lwaa_pkg::cfg_t                      cfg,
    input  logic [lwaa_pkg::MAX_NODES-1:0]      ack_bits,
    input  logic [lwaa_pkg::AHEAD_W-1:0]        weight_ahead,
    output logic                                grant_ok
);
    import lwaa_pkg::*;

    logic [MAX_NODES-1:0] have;
    logic [MAX_NODES-1:0] need_mask;
    logic [LEN_W-1:0]     need_cnt;
    logic                 acks_ok;
    logic [CAP_W:0]       total;

    // The own node always counts as acknowledged.
    always_comb begin
        have = ack_bits;
        have[cfg.my_rank[IDX_W-1:0]] = 1'b1;
    end

    // Nodes below the clamped node count must all have acked.
    always_comb begin
        if (cfg.node_count > COUNT_W'(MAX_NODES)) begin
            need_cnt = LEN_W'(MAX_NODES);
        end else begin
            need_cnt = LEN_W'(cfg.node_count);
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            need_mask[i] = (LEN_W'(i) < need_cnt);
        end
    end

    assign acks_ok = &(have | ~need_mask);

    // Weight queued ahead plus the own weight must fit the capacity.
    assign total    = (CAP_W+1)'(weight_ahead) + (CAP_W+1)'(cfg.my_weight);
    assign grant_ok = acks_ok && (total <= (CAP_W+1)'(cfg.capacity));

endmodule
